// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// Each check is sampled on the rising edge of clk and is quiet during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// When ante holds, cons must hold on the next clock edge.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- src/mvt_pkg.sv -----
// ---------------------------------------------------------------------------
// mvt_pkg
// Types and constants of the 4x4 matrix-vector transform unit.
// ---------------------------------------------------------------------------
package mvt_pkg;

  localparam int NUM_REGS = 8;
  localparam int REG_W    = 64;
  localparam int IDX_W    = 3;
  localparam int COEF_W   = 32;
  localparam int PROD_W   = 2 * COEF_W;
  localparam int DIM      = 4;

  // Identity matrix at Q16.16: each register holds two coefficients of a row.
  localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  localparam logic signed [COEF_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [COEF_W-1:0] in_x;
    logic signed [COEF_W-1:0] in_y;
    logic signed [COEF_W-1:0] in_z;
    logic signed [COEF_W-1:0] in_w;
  } in_word_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] out_x;
    logic signed [COEF_W-1:0] out_y;
    logic signed [COEF_W-1:0] out_z;
    logic signed [COEF_W-1:0] out_w;
    logic                     overflow;
  } out_word_t;

endpackage

// ----- src/matrix_vector_transform_4x4.sv -----
// ---------------------------------------------------------------------------
// matrix_vector_transform_4x4
// Streaming 4x4 fixed-point matrix times vector with saturation.
// ---------------------------------------------------------------------------
// Usage:
//   The matrix is loaded through the cfg_ port: cfg_we writes cfg_data into
//   register cfg_index, two signed coefficients of one row per register.
//   The user must make writes only while no word is in flight; the block does not enforce it.
//   Input words (x, y, z, w) enter on in_valid / in_stall, results leave on
//   out_valid / out_stall. A word is moved when valid is high and stall low.
//   Words pass through products, pair sums, row sums, then shift and
//   saturation into the output register. One word is accepted each cycle
//   that in_stall is low; the sixteen 32x32 multipliers and the two adder
//   levels are each one pipeline stage, so that single pass sets the rate.
//   When the receiver stalls, words advance only into empty stages; in_stall
//   rises once every stage holds a word.
//   Reset empties the pipeline and loads the identity matrix.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_vector_transform_4x4
  import mvt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_data
);

  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  logic [REG_W-1:0] coef_r [NUM_REGS];

  logic signed [COEF_W-1:0] coef    [DIM][DIM];
  logic signed [COEF_W-1:0] vec     [DIM];

  logic signed [PROD_W-1:0] prod_r  [DIM][DIM];
  logic signed [PAIR_W-1:0] pair_r  [DIM][2];
  logic signed [SUM_W-1:0]  row_r   [DIM];
  logic signed [COEF_W-1:0] comp    [DIM];
  logic                     sat     [DIM];

  logic      v1_r, v2_r, v3_r, out_valid_r;
  logic      en1, en2, en3, en_out;
  out_word_t out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_we) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        coef[r][c] = coef_r[2 * r + c / 2][COEF_W * (c % 2) +: COEF_W];
      end
    end
    vec[0] = in_data.in_x;
    vec[1] = in_data.in_y;
    vec[2] = in_data.in_z;
    vec[3] = in_data.in_w;
  end

  // A stage takes a new word when it is empty or its word moves on.
  assign en_out   = !out_valid_r || !out_stall;
  assign en3      = !v3_r || en_out;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en_out) begin
        out_valid_r <= v3_r;
      end
    end
  end

  // Stage 1: sixteen full-precision products.
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          prod_r[r][c] <= PROD_W'(coef[r][c]) * PROD_W'(vec[c]);
        end
      end
    end
  end

  // Stage 2: pairwise sums within each row.
  always_ff @(posedge clk) begin
    if (en2) begin
      for (int r = 0; r < DIM; r++) begin
        for (int k = 0; k < 2; k++) begin
          pair_r[r][k] <= PAIR_W'(prod_r[r][2 * k]) + PAIR_W'(prod_r[r][2 * k + 1]);
        end
      end
    end
  end

  // Stage 3: exact row sums; four 64-bit products fit in 66 bits.
  always_ff @(posedge clk) begin
    if (en3) begin
      for (int r = 0; r < DIM; r++) begin
        row_r[r] <= SUM_W'(pair_r[r][0]) + SUM_W'(pair_r[r][1]);
      end
    end
  end

  // Stage 4: arithmetic shift, then clamp when the upper bits are not all sign.
  always_comb begin
    logic signed [SUM_W-1:0] shifted;
    for (int r = 0; r < DIM; r++) begin
      shifted = row_r[r] >>> FRAC_BITS;
      sat[r]  = !((&shifted[SUM_W-1:COEF_W-1]) || !(|shifted[SUM_W-1:COEF_W-1]));
      if (!sat[r]) begin
        comp[r] = shifted[COEF_W-1:0];
      end else if (row_r[r][SUM_W-1]) begin
        comp[r] = SAT_MIN;
      end else begin
        comp[r] = SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r.out_x    <= comp[0];
      out_data_r.out_y    <= comp[1];
      out_data_r.out_z    <= comp[2];
      out_data_r.out_w    <= comp[3];
      out_data_r.overflow <= sat[0] | sat[1] | sat[2] | sat[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The input is held off only when every stage is occupied and blocked.
  `ASSERT_ALWAYS(a_stall_full, !in_stall || (v1_r && v2_r && v3_r && out_valid_r && out_stall))
  // An accepted word occupies the first stage on the next cycle.
  `ASSERT_NEXT(a_accept_fill, in_valid && !in_stall, v1_r)
  // With the output free, the last stage drains into the output register.
  `ASSERT_NEXT(a_drain, en_out, out_valid_r == $past(v3_r))
  // A flagged result carries at least one clamped component.
  `ASSERT_ALWAYS(a_ovf_clamp, !(out_valid_r && out_data_r.overflow) ||
    (out_data_r.out_x == SAT_MAX || out_data_r.out_x == SAT_MIN ||
     out_data_r.out_y == SAT_MAX || out_data_r.out_y == SAT_MIN ||
     out_data_r.out_z == SAT_MAX || out_data_r.out_z == SAT_MIN ||
     out_data_r.out_w == SAT_MAX || out_data_r.out_w == SAT_MIN))

endmodule

// ----- verif/tb_matrix_vector_transform_4x4.sv -----
// ---------------------------------------------------------------------------
// tb_matrix_vector_transform_4x4
// Drives vectors through the 4x4 transform unit under several matrices and
// idle patterns. A scoreboard predicts each saturated product and compares
// every output word field by field, in order.
// ---------------------------------------------------------------------------
module tb_matrix_vector_transform_4x4;
  timeunit 1ns;
  timeprecision 1ps;

  import mvt_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int PHASES = 12;
  localparam int VECTORS_PER_PHASE = 100;
  localparam logic [COEF_W-1:0] ONE = 32'h0001_0000;
  localparam logic [COEF_W-1:0] HALF = 32'h0000_8000;
  localparam logic [COEF_W-1:0] MINUS_ONE = 32'hFFFF_0000;
  localparam logic [COEF_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam int REG_ROW0_COLS01 = 0;
  localparam int REG_ROW0_COLS23 = 1;
  localparam int REG_ROW1_COLS01 = 2;
  localparam int REG_ROW1_COLS23 = 3;
  localparam int REG_ROW2_COLS01 = 4;
  localparam int REG_ROW2_COLS23 = 5;
  localparam int REG_ROW3_COLS01 = 6;
  localparam int REG_ROW3_COLS23 = 7;

  typedef logic [REG_W-1:0] matrix_t [NUM_REGS];

  typedef enum {STYLE_FULL, STYLE_SMALL, STYLE_AFFINE, STYLE_EXTREME, STYLE_3X3}
    matrix_style_t;
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  class xform_scoreboard;
    logic [REG_W-1:0] coef_regs [NUM_REGS];
    out_word_t expected_xforms [$];
    int mismatches;

    function new();
      coef_regs = CFG_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(int idx, logic [REG_W-1:0] val);
      coef_regs[idx] = val;
    endfunction

    // Exact dot products, arithmetic shift, then clamp each row to 32 bits.
    function out_word_t apply_matrix(in_word_t v);
      logic signed [COEF_W-1:0] comp [DIM];
      logic signed [COEF_W-1:0] coef;
      logic signed [PROD_W-1:0] prod;
      logic signed [127:0] acc;
      logic signed [127:0] scaled;
      logic [COEF_W-1:0] row_out [DIM];
      logic sat;
      out_word_t res;
      comp[0] = v.in_x;
      comp[1] = v.in_y;
      comp[2] = v.in_z;
      comp[3] = v.in_w;
      sat = 1'b0;
      for (int r = 0; r < DIM; r++) begin
        acc = '0;
        for (int c = 0; c < DIM; c++) begin
          coef = coef_regs[2*r + c/2][32*(c%2) +: 32];
          prod = coef * comp[c];
          acc = acc + prod;
        end
        scaled = acc >>> FRAC_BITS;
        if (scaled[127:31] == '0 || &scaled[127:31]) begin
          row_out[r] = scaled[31:0];
        end else begin
          sat = 1'b1;
          row_out[r] = scaled[127] ? SAT_MIN : SAT_MAX;
        end
      end
      res.out_x = row_out[0];
      res.out_y = row_out[1];
      res.out_z = row_out[2];
      res.out_w = row_out[3];
      res.overflow = sat;
      return res;
    endfunction

    function void note_vector(in_word_t v);
      expected_xforms.push_back(apply_matrix(v));
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_xform(out_word_t got);
      out_word_t want;
      if (expected_xforms.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output word, expected none, got %h", $time, got);
        return;
      end
      want = expected_xforms.pop_front();
      check_field("out_x", want.out_x, got.out_x);
      check_field("out_y", want.out_y, got.out_y);
      check_field("out_z", want.out_z, got.out_z);
      check_field("out_w", want.out_w, got.out_w);
      check_field("overflow", {31'b0, want.overflow}, {31'b0, got.overflow});
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  xform_scoreboard sb;

  matrix_vector_transform_4x4 #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: check each word that moves, then choose the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_xform(out_data);
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [COEF_W-1:0] extreme_value();
    case ($urandom_range(4))
      0: return SAT_MIN;
      1: return SAT_MAX;
      2: return '0;
      3: return ALL_ONES;
      default: return ONE;
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] small_value(int bits);
    return 32'($urandom_range((1 << (bits + 1)) - 1)) - (32'd1 << bits);
  endfunction

  function automatic logic [COEF_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1: return extreme_value();
      2, 3, 4: return small_value(20);
      default: return $urandom();
    endcase
  endfunction

  function automatic in_word_t vec(logic [31:0] x, logic [31:0] y,
                                   logic [31:0] z, logic [31:0] w);
    in_word_t v;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    v.in_w = w;
    return v;
  endfunction

  function automatic in_word_t make_vector(matrix_style_t style);
    return vec(pick_value(), pick_value(), pick_value(),
               (style == STYLE_3X3) ? '0 : pick_value());
  endfunction

  function automatic matrix_t make_matrix(matrix_style_t style);
    matrix_t m;
    logic [COEF_W-1:0] c;
    for (int r = 0; r < DIM; r++) begin
      for (int col = 0; col < DIM; col++) begin
        case (style)
          STYLE_FULL: c = pick_value();
          STYLE_SMALL: c = small_value(18);
          STYLE_AFFINE: c = (r == 3) ? ((col == 3) ? ONE : '0) : small_value(18);
          STYLE_EXTREME: c = extreme_value();
          default: c = (r == 3 || col == 3) ? '0 : pick_value();
        endcase
        m[2*r + col/2][32*(col%2) +: 32] = c;
      end
    end
    return m;
  endfunction

  task automatic set_idling(idle_mode_t mode);
    idle_pct = (mode == IDLE_SENDER) ? 57 : (mode == IDLE_BOTH) ? 12 : 0;
    stall_pct = (mode == IDLE_RECEIVER) ? 57 : (mode == IDLE_BOTH) ? 12 : 0;
  endtask

  task automatic send_vector(in_word_t v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_vector(v);
  endtask

  // Stop sending, then wait until every word in flight has come out.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (sb.expected_xforms.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_matrix(matrix_t m);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_data <= m[i];
      @(posedge clk);
      sb.write_reg(i, m[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    matrix_t m;
    matrix_style_t style;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity after reset: values pass through unchanged.
    set_idling(IDLE_NONE);
    send_vector(vec('0, '0, '0, '0));
    send_vector(vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
    send_vector(vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
    send_vector(vec(32'd1, ALL_ONES, ONE, MINUS_ONE));
    send_vector(vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0));

    // Most negative coefficients everywhere: both saturation directions.
    drain_pipeline();
    foreach (m[i]) m[i] = {SAT_MIN, SAT_MIN};
    load_matrix(m);
    send_vector(vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
    send_vector(vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
    send_vector(vec(32'd1, '0, '0, '0));
    send_vector(vec('0, '0, '0, '0));

    // 3x3 case with a zero fourth row and column; rows saturate separately.
    drain_pipeline();
    m[REG_ROW0_COLS01] = {SAT_MAX, SAT_MAX};
    m[REG_ROW0_COLS23] = {32'h0, SAT_MAX};
    m[REG_ROW1_COLS01] = {SAT_MAX, SAT_MIN};
    m[REG_ROW1_COLS23] = {32'h0, SAT_MIN};
    m[REG_ROW2_COLS01] = {MINUS_ONE, ONE};
    m[REG_ROW2_COLS23] = {32'h0, HALF};
    m[REG_ROW3_COLS01] = '0;
    m[REG_ROW3_COLS23] = '0;
    load_matrix(m);
    send_vector(vec(SAT_MAX, SAT_MAX, SAT_MAX, '0));
    send_vector(vec(SAT_MIN, SAT_MAX, SAT_MIN, '0));
    send_vector(vec(ONE, 32'h0002_0000, 32'hFFFF_8000, '0));
    send_vector(vec(32'd3, 32'd5, -32'sd7, '0));
    send_vector(vec(ONE, '0, '0, '0));

    for (int p = 0; p < PHASES; p++) begin
      style = matrix_style_t'(p % 5);
      drain_pipeline();
      load_matrix(make_matrix(style));
      set_idling(idle_mode_t'(p % 4));
      for (int i = 0; i < VECTORS_PER_PHASE; i++) begin
        if (i == VECTORS_PER_PHASE / 2 && p % 3 == 1) begin
          drain_pipeline();
        end
        send_vector(make_vector(style));
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_xforms.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.expected_xforms.size() != 0) begin
      $display("%0t: %0d output words never arrived", $time, sb.expected_xforms.size());
    end
    if (sb.mismatches == 0 && sb.expected_xforms.size() == 0) begin
      $display("tb_matrix_vector_transform_4x4: clean");
    end else begin
      $display("tb_matrix_vector_transform_4x4: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_matrix_vector_transform_4x4: errors");
    $finish;
  end

endmodule
